FILE: rtl/core/pfc_pkg.sv
package pfc_pkg;

   localparam int HEADER_BYTES        = 7;
   localparam int MAX_PAYLOAD_DEFAULT = 64;

   localparam logic [7:0] SYNC_A   = 8'h5A;
   localparam logic [7:0] SYNC_B   = 8'hA5;
   localparam logic [7:0] CRC_POLY = 8'h2F;
   localparam logic [7:0] CRC_SEED = 8'h00;

   // header positions
   localparam logic [7:0] POS_SYNC   = 8'd0;
   localparam logic [7:0] POS_ID     = 8'd1;
   localparam logic [7:0] POS_LENGTH = 8'd6;

   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_OK    = 3'd0,
      VERDICT_SIZE  = 3'd1,
      VERDICT_SYNC  = 3'd2,
      VERDICT_SHORT = 3'd3,
      VERDICT_CRC   = 3'd4
   } verdict_type;

   // one byte through the CRC-8, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/pfc_req_if.sv
interface pfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_buffer;

   modport source (output valid, output rx_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

FILE: rtl/core/pfc_rsp_if.sv
interface pfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [2:0]  verdict;
   logic [7:0]  sync_seen;
   logic [7:0]  packet_id;
   logic [31:0] time_stamp;
   logic [7:0]  payload_count;
   logic [7:0]  crc_received;
   logic        last_of_run;

   modport source (output valid, output result_kind, output payload_byte, output verdict,
                   output sync_seen, output packet_id, output time_stamp,
                   output payload_count, output crc_received, output last_of_run,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte, input verdict,
                   input sync_seen, input packet_id, input time_stamp,
                   input payload_count, input crc_received, input last_of_run,
                   output ready);
endinterface

FILE: rtl/core/packet_frame_checker_crc8_core.sv
// Channel   Direction  Carries
// req_chan  in         rx_byte, end_of_buffer
// rsp_chan  out        result_kind, payload_byte, verdict, header fields, last_of_run
//
// One byte per cycle is taken while req_chan.ready is high; header capture and the
// CRC update complete in the cycle the byte is accepted, and its results are held
// in a two-slot output stage. A final byte that is also a payload byte gives two results
// from one slot; req_chan.ready drops only when both slots are full.
// Synchronous active-high reset clears frame state and the output stage.
// Stalls on rsp_chan back up into req_chan after one extra buffered item.
module packet_frame_checker_crc8_core #(
   parameter int MAX_PAYLOAD = pfc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   pfc_req_if.sink  req_chan,
   pfc_rsp_if.source rsp_chan
);
   import pfc_pkg::*;

   localparam logic [8:0] PAY_LIMIT  = 9'(HEADER_BYTES + MAX_PAYLOAD);
   localparam logic [8:0] SIZE_LIMIT = 9'(HEADER_BYTES + MAX_PAYLOAD + 1);
   localparam logic [8:0] HDR_LEN    = 9'(HEADER_BYTES);

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  sync_seen;
      logic [7:0]  packet_id;
      logic [31:0] time_stamp;
      logic [7:0]  payload_count;
      logic [7:0]  crc_received;
   } report_type;

   typedef struct packed {
      logic       pay_valid;
      logic [7:0] pay_byte;
      logic       verd_valid;
      report_type report;
   } slot_type;

   logic [7:0]  byte_count_ff, byte_count_in;
   logic        count_overflow_ff, count_overflow_in;
   logic [7:0]  running_crc_ff, running_crc_in;
   logic [7:0]  sync_reg_ff, sync_reg_in;
   logic [7:0]  id_reg_ff, id_reg_in;
   logic [31:0] stamp_reg_ff, stamp_reg_in;
   logic [7:0]  length_reg_ff, length_reg_in;
   logic [7:0]  crc_reg_ff, crc_reg_in;
   logic        crc_seen_ff, crc_seen_in;

   slot_type out_ff, out_in;
   slot_type skid_ff, skid_in;
   slot_type fresh;

   logic       accept;
   logic       out_busy;
   logic       skid_busy;
   logic       rsp_take;
   logic [8:0] pos;
   logic [8:0] pay_end;
   logic       in_header;
   logic       in_payload;
   logic [8:0] total;
   logic [8:0] need;
   logic [7:0] b;

   assign b         = req_chan.rx_byte;
   assign out_busy  = out_ff.pay_valid | out_ff.verd_valid;
   assign skid_busy = skid_ff.pay_valid | skid_ff.verd_valid;
   assign req_chan.ready = !skid_busy;
   assign accept    = req_chan.valid & req_chan.ready;
   assign rsp_take  = rsp_chan.valid & rsp_chan.ready;

   assign pos        = {1'b0, byte_count_ff};
   assign pay_end    = HDR_LEN + {1'b0, length_reg_ff};
   assign in_header  = pos < HDR_LEN;
   assign in_payload = !in_header && (pos < pay_end);

   // frame state update and result formation for the byte at the input
   always_comb begin
      byte_count_in     = byte_count_ff;
      count_overflow_in = count_overflow_ff;
      running_crc_in    = running_crc_ff;
      sync_reg_in       = sync_reg_ff;
      id_reg_in         = id_reg_ff;
      stamp_reg_in      = stamp_reg_ff;
      length_reg_in     = length_reg_ff;
      crc_reg_in        = crc_reg_ff;
      crc_seen_in       = crc_seen_ff;
      fresh             = '0;
      total             = '0;
      need              = '0;

      if (!count_overflow_ff) begin
         if (in_header || in_payload) begin
            running_crc_in = crc8_step(running_crc_ff, b);
         end
         if (in_header) begin
            if (byte_count_ff == POS_SYNC) begin
               sync_reg_in = b;
            end else if (byte_count_ff == POS_ID) begin
               id_reg_in = b;
            end else if (byte_count_ff == POS_LENGTH) begin
               length_reg_in = b;
            end else begin
               stamp_reg_in = stamp_reg_ff
                            | (32'(b) << {2'(byte_count_ff[2:0] - 3'd2), 3'b000});
            end
         end else if (in_payload) begin
            if (pos < PAY_LIMIT) begin
               fresh.pay_valid = 1'b1;
               fresh.pay_byte  = b;
            end
         end else if (pos == pay_end && !crc_seen_ff) begin
            crc_reg_in  = b;
            crc_seen_in = 1'b1;
         end

         if (byte_count_ff == 8'hFF) begin
            count_overflow_in = 1'b1;
         end else begin
            byte_count_in = byte_count_ff + 8'd1;
         end
      end

      if (req_chan.end_of_buffer) begin
         total = count_overflow_in ? 9'd256 : {1'b0, byte_count_in};
         need  = HDR_LEN + {1'b0, length_reg_in} + 9'd1;

         fresh.verd_valid = 1'b1;
         if (total > SIZE_LIMIT) begin
            fresh.report.verdict = VERDICT_SIZE;
         end else if (sync_reg_in != SYNC_A && sync_reg_in != SYNC_B) begin
            fresh.report.verdict = VERDICT_SYNC;
         end else if (total < HDR_LEN || total < need) begin
            fresh.report.verdict = VERDICT_SHORT;
         end else if (running_crc_in != crc_reg_in) begin
            fresh.report.verdict = VERDICT_CRC;
         end else begin
            fresh.report.verdict = VERDICT_OK;
         end
         fresh.report.sync_seen     = sync_reg_in;
         fresh.report.packet_id     = id_reg_in;
         fresh.report.time_stamp    = stamp_reg_in;
         fresh.report.payload_count = length_reg_in;
         fresh.report.crc_received  = crc_reg_in;

         // buffer done: start over
         byte_count_in     = '0;
         count_overflow_in = 1'b0;
         running_crc_in    = CRC_SEED;
         sync_reg_in       = '0;
         id_reg_in         = '0;
         stamp_reg_in      = '0;
         length_reg_in     = '0;
         crc_reg_in        = '0;
         crc_seen_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff     <= '0;
         count_overflow_ff <= 1'b0;
         running_crc_ff    <= CRC_SEED;
         sync_reg_ff       <= '0;
         id_reg_ff         <= '0;
         stamp_reg_ff      <= '0;
         length_reg_ff     <= '0;
         crc_reg_ff        <= '0;
         crc_seen_ff       <= 1'b0;
      end else if (accept) begin
         byte_count_ff     <= byte_count_in;
         count_overflow_ff <= count_overflow_in;
         running_crc_ff    <= running_crc_in;
         sync_reg_ff       <= sync_reg_in;
         id_reg_ff         <= id_reg_in;
         stamp_reg_ff      <= stamp_reg_in;
         length_reg_ff     <= length_reg_in;
         crc_reg_ff        <= crc_reg_in;
         crc_seen_ff       <= crc_seen_in;
      end
   end

   // output slot and skid slot
   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;

      if (rsp_take) begin
         if (out_ff.pay_valid && out_ff.verd_valid) begin
            out_in.pay_valid = 1'b0;
         end else begin
            out_in.pay_valid  = 1'b0;
            out_in.verd_valid = 1'b0;
         end
      end

      if (!(out_in.pay_valid || out_in.verd_valid)) begin
         if (skid_busy) begin
            // advance the skid item; a new item takes its place
            out_in  = skid_ff;
            skid_in.pay_valid  = 1'b0;
            skid_in.verd_valid = 1'b0;
            if (accept && (fresh.pay_valid || fresh.verd_valid)) begin
               skid_in = fresh;
            end
         end else if (accept && (fresh.pay_valid || fresh.verd_valid)) begin
            out_in = fresh;
         end
      end else if (accept && (fresh.pay_valid || fresh.verd_valid)) begin
         skid_in = fresh;
      end
   end

   always_ff @(posedge clock) begin
      out_ff.pay_byte  <= out_in.pay_byte;
      out_ff.report    <= out_in.report;
      skid_ff.pay_byte <= skid_in.pay_byte;
      skid_ff.report   <= skid_in.report;
      if (reset) begin
         out_ff.pay_valid   <= 1'b0;
         out_ff.verd_valid  <= 1'b0;
         skid_ff.pay_valid  <= 1'b0;
         skid_ff.verd_valid <= 1'b0;
      end else begin
         out_ff.pay_valid   <= out_in.pay_valid;
         out_ff.verd_valid  <= out_in.verd_valid;
         skid_ff.pay_valid  <= skid_in.pay_valid;
         skid_ff.verd_valid <= skid_in.verd_valid;
      end
   end

   // payload result goes first when a slot holds both
   always_comb begin
      rsp_chan.valid         = out_busy;
      rsp_chan.result_kind   = RESULT_PAYLOAD;
      rsp_chan.payload_byte  = '0;
      rsp_chan.verdict       = '0;
      rsp_chan.sync_seen     = '0;
      rsp_chan.packet_id     = '0;
      rsp_chan.time_stamp    = '0;
      rsp_chan.payload_count = '0;
      rsp_chan.crc_received  = '0;
      rsp_chan.last_of_run   = 1'b1;
      if (out_ff.pay_valid) begin
         rsp_chan.payload_byte = out_ff.pay_byte;
         rsp_chan.last_of_run  = !out_ff.verd_valid;
      end else begin
         rsp_chan.result_kind   = RESULT_VERDICT;
         rsp_chan.verdict       = out_ff.report.verdict;
         rsp_chan.sync_seen     = out_ff.report.sync_seen;
         rsp_chan.packet_id     = out_ff.report.packet_id;
         rsp_chan.time_stamp    = out_ff.report.time_stamp;
         rsp_chan.payload_count = out_ff.report.payload_count;
         rsp_chan.crc_received  = out_ff.report.crc_received;
      end
   end

   skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_busy |-> out_busy)
      else $error("skid slot holds an item while the output slot is empty");

   clear_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_of_buffer |=> byte_count_ff == 8'd0 && !crc_seen_ff)
      else $error("frame state not cleared after the final byte");

   overflow_at_top: assert property (@(posedge clock) disable iff (reset)
      count_overflow_ff |-> byte_count_ff == 8'hFF)
      else $error("count overflow without a saturated byte count");

   crc_after_header: assert property (@(posedge clock) disable iff (reset)
      crc_seen_ff |-> byte_count_ff > 8'(HEADER_BYTES))
      else $error("CRC byte captured inside the header");

endmodule

FILE: test/tb_packet_frame_checker_crc8_core.sv
module tb_packet_frame_checker_crc8_core;
   import pfc_pkg::*;

   localparam int FRAME_PAYLOAD_MAX = MAX_PAYLOAD_DEFAULT;
   localparam int FRAME_LIMIT       = HEADER_BYTES + FRAME_PAYLOAD_MAX + 1;
   localparam int PHASE_ITEMS       = 250;
   localparam int LONG_HOLD         = 300;
   localparam int STUCK_LIMIT       = 4000;
   localparam int DRAIN_CYCLES      = 20;

   typedef struct packed {
      logic [7:0] data;
      logic       eob;
   } rx_item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload;
      verdict_type verdict;
      logic [7:0]  sync;
      logic [7:0]  id;
      logic [31:0] stamp;
      logic [7:0]  length;
      logic [7:0]  crc;
      logic        last;
   } frame_result_type;

   logic clock;
   logic reset;

   pfc_req_if req_chan ();
   pfc_rsp_if rsp_chan ();

   packet_frame_checker_crc8_core #(.MAX_PAYLOAD(FRAME_PAYLOAD_MAX)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rx_item_type      bytes_to_send[$];
   frame_result_type outcomes_due[$];
   int            queued_items   = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            hold_requests  = 0;
   int            holds_served   = 0;
   int            hold_left      = 0;
   int            stuck_cycles   = 0;
   int            fault_count    = 0;

   // receive-side frame state
   logic [7:0]  seen_count;
   logic        count_sat;
   logic [7:0]  crc_run;
   logic [7:0]  got_sync;
   logic [7:0]  got_id;
   logic [31:0] got_stamp;
   logic [7:0]  got_len;
   logic [7:0]  got_crc;
   logic        crc_taken;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
   endfunction

   function automatic void clear_frame_state();
      seen_count = 8'h00;
      count_sat  = 1'b0;
      crc_run    = CRC_SEED;
      got_sync   = 8'h00;
      got_id     = 8'h00;
      got_stamp  = 32'h0;
      got_len    = 8'h00;
      got_crc    = 8'h00;
      crc_taken  = 1'b0;
   endfunction

   function automatic void absorb_rx_byte(input logic [7:0] b, input logic eob);
      frame_result_type r;
      int pos, pay_end, total, need;
      if (!count_sat) begin
         pos     = seen_count;
         pay_end = HEADER_BYTES + got_len;
         if (pos < HEADER_BYTES) begin
            crc_run = crc8_next(crc_run, b);
            if (pos == POS_SYNC) got_sync = b;
            else if (pos == POS_ID) got_id = b;
            else if (pos < POS_LENGTH) got_stamp[8*(pos-2) +: 8] = b;
            else got_len = b;
         end else if (pos < pay_end) begin
            crc_run = crc8_next(crc_run, b);
            // payload past the size limit is hashed but not passed out
            if (pos < HEADER_BYTES + FRAME_PAYLOAD_MAX) begin
               r         = '0;
               r.kind    = RESULT_PAYLOAD;
               r.payload = b;
               r.last    = !eob;
               outcomes_due.push_back(r);
            end
         end else if (pos == pay_end && !crc_taken) begin
            got_crc   = b;
            crc_taken = 1'b1;
         end
         if (seen_count == 8'hFF) count_sat = 1'b1;
         else seen_count++;
      end
      if (eob) begin
         total  = count_sat ? 256 : seen_count;
         need   = HEADER_BYTES + got_len + 1;
         r      = '0;
         r.kind = RESULT_VERDICT;
         if (total > FRAME_LIMIT) r.verdict = VERDICT_SIZE;
         else if (got_sync != SYNC_A && got_sync != SYNC_B) r.verdict = VERDICT_SYNC;
         else if (total < HEADER_BYTES || total < need) r.verdict = VERDICT_SHORT;
         else if (crc_run != got_crc) r.verdict = VERDICT_CRC;
         else r.verdict = VERDICT_OK;
         r.sync   = got_sync;
         r.id     = got_id;
         r.stamp  = got_stamp;
         r.length = got_len;
         r.crc    = got_crc;
         r.last   = 1'b1;
         outcomes_due.push_back(r);
         clear_frame_state();
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic eob);
      rx_item_type it;
      it.data = b;
      it.eob  = eob;
      bytes_to_send.push_back(it);
      queued_items++;
   endfunction

   // keep of 0 sends the whole frame, otherwise cut it to keep bytes
   function automatic void queue_frame(input logic [7:0] sync, input logic [7:0] id,
                                       input logic [31:0] stamp, input int len,
                                       input int keep, input int trail,
                                       input logic [7:0] crc_flip);
      logic [7:0] img[$];
      logic [7:0] crc;
      img = {sync, id, stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24], 8'(len)};
      repeat (len) img.push_back(8'($urandom));
      crc = CRC_SEED;
      foreach (img[i]) crc = crc8_next(crc, img[i]);
      img.push_back(crc ^ crc_flip);
      repeat (trail) img.push_back(8'($urandom));
      if (keep > 0) while (img.size() > keep) void'(img.pop_back());
      foreach (img[i]) push_byte(img[i], i == img.size() - 1);
   endfunction

   function automatic void queue_random_frame();
      int pick, len, keep, trail;
      logic [7:0] sync, flip;
      pick  = $urandom_range(99);
      sync  = $urandom_range(1) ? SYNC_A : SYNC_B;
      len   = ($urandom_range(9) == 0) ? $urandom_range(FRAME_PAYLOAD_MAX) : $urandom_range(12);
      keep  = 0;
      trail = ($urandom_range(6) == 0) ? $urandom_range(1, 3) : 0;
      flip  = ($urandom_range(6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (pick >= 94) begin
         // short garbage
         sync = 8'($urandom);
         len  = $urandom_range(255);
         keep = $urandom_range(1, 12);
      end else if (pick >= 88) begin
         len  = $urandom_range(255);
         keep = $urandom_range(FRAME_LIMIT + 1, 100);
      end else if (pick >= 80) begin
         len = $urandom_range(FRAME_PAYLOAD_MAX + 1, FRAME_PAYLOAD_MAX + 26);
      end else if (pick >= 70) begin
         sync = 8'($urandom);
      end else if (pick >= 55) begin
         // cut anywhere before the CRC byte
         keep = $urandom_range(1, HEADER_BYTES + len);
      end
      queue_frame(sync, 8'($urandom), $urandom, len, keep, trail, flip);
   endfunction

   function automatic void report_result(input string tag, input frame_result_type r);
      $display("  %s kind=%0d byte=%h verdict=%0d sync=%h id=%h stamp=%h len=%h crc=%h last=%0d",
               tag, r.kind, r.payload, r.verdict, r.sync, r.id, r.stamp, r.length, r.crc,
               r.last);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin : drive_req
      rx_item_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) absorb_rx_byte(req_chan.rx_byte, req_chan.end_of_buffer);
         if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = bytes_to_send.pop_front();
            req_chan.valid         <= 1'b1;
            req_chan.rx_byte       <= nxt.data;
            req_chan.end_of_buffer <= nxt.eob;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver readiness, with long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served   <= holds_served + 1;
         hold_left      <= LONG_HOLD;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      frame_result_type seen, due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.kind    = rsp_chan.result_kind;
         seen.payload = rsp_chan.payload_byte;
         seen.verdict = verdict_type'(rsp_chan.verdict);
         seen.sync    = rsp_chan.sync_seen;
         seen.id      = rsp_chan.packet_id;
         seen.stamp   = rsp_chan.time_stamp;
         seen.length  = rsp_chan.payload_count;
         seen.crc     = rsp_chan.crc_received;
         seen.last    = rsp_chan.last_of_run;
         if (outcomes_due.size() == 0) begin
            if (fault_count < 10) begin
               $display("result with nothing pending at %0t", $realtime);
               report_result("actual  ", seen);
            end
            fault_count++;
         end else begin
            due = outcomes_due.pop_front();
            if (seen !== due) begin
               if (fault_count < 10) begin
                  $display("result mismatch at %0t", $realtime);
                  report_result("expected", due);
                  report_result("actual  ", seen);
               end
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int phase, target;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.rx_byte       = 8'h00;
      req_chan.end_of_buffer = 1'b0;
      rsp_chan.ready         = 1'b0;
      clear_frame_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone bytes: bad sync at both extremes, then a good sync with no header
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(SYNC_A, 1'b1);
      // empty payload, all-ones ID and time stamp, clean
      queue_frame(SYNC_B, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 8'h00);
      // one payload byte, bad CRC, one trailing byte
      queue_frame(SYNC_A, 8'h00, 32'h0000_0000, 1, 0, 1, 8'hFF);

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3: begin send_idle_pct = 31; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) begin
            // hold the output while the sender keeps pushing
            hold_requests <= hold_requests + 1;
            queue_frame(SYNC_A, 8'($urandom), $urandom, FRAME_PAYLOAD_MAX, 0, 0, 8'h00);
            // runs past a byte count of 255
            queue_frame(SYNC_B, 8'($urandom), $urandom, 255, 0, 7, 8'h00);
         end
         target = queued_items + PHASE_ITEMS;
         while (queued_items < target) queue_random_frame();
         while (bytes_to_send.size() > 0 || req_chan.valid) @(negedge clock);
      end

      while (outcomes_due.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: packet_frame_checker_crc8_core.f
rtl/core/pfc_pkg.sv
rtl/core/pfc_req_if.sv
rtl/core/pfc_rsp_if.sv
rtl/core/packet_frame_checker_crc8_core.sv
test/tb_packet_frame_checker_crc8_core.sv
